// File: hw/rtl/gbt_pkg.sv
//------------------------------------------------------------------------------
// gbt_pkg
// Shared types and codes for the graph walker.
//------------------------------------------------------------------------------
`default_nettype none
package gbt_pkg;
	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_BFS   = 2'd1;
	localparam logic [1:0] ACT_DFS   = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] MARK_FREE = 2'd0;
	localparam logic [1:0] MARK_WAIT = 2'd1;
	localparam logic [1:0] MARK_DONE = 2'd2;

	localparam logic [0:0] REG_VERTEX_COUNT = 1'd0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EMIT,
		S_RDREQ,
		S_SCAN,
		S_POP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture command and decode
		logic edge_wr;    // write edge, bump degree
		logic clear;      // zero degrees
		logic emit_stat;  // status-only result
		logic emit_cur;   // result for current vertex
		logic walk_init;  // clear marks, set start vertex
		logic scan_step;  // consume read data, advance index
		logic pop;        // move frontier pointer
		logic take;       // latch popped vertex as current
	} gbt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_walk;
		logic bad;
		logic scan_done;  // index reached degree
		logic empty;      // frontier empty
	} gbt_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/gbt_ram.sv
//------------------------------------------------------------------------------
// gbt_ram
// Generic single-port-write, one-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module gbt_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: hw/rtl/gbt_ctrl.sv
//------------------------------------------------------------------------------
// gbt_ctrl
// Sequencer for edge loads, clears and graph walks.
//------------------------------------------------------------------------------
`default_nettype none
module gbt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire gbt_pkg::gbt_sts_t sts,
	output gbt_pkg::gbt_cmd_t      cmd
);
	import gbt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!sts.is_walk || sts.bad) begin
					cmd.emit_stat = 1'b1;
					cmd.edge_wr   = 1'b1;
					cmd.clear     = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = S_RDREQ;
				end
			end
			S_RDREQ: begin
				if (sts.scan_done) begin
					cmd.emit_cur = 1'b1;
					cmd.pop      = 1'b1;
					state_d      = sts.empty ? S_IDLE : S_POP;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				state_d       = S_RDREQ;
			end
			S_POP: begin
				cmd.take = 1'b1;
				state_d  = S_RDREQ;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// File: hw/rtl/gbt_dp.sv
//------------------------------------------------------------------------------
// gbt_dp
// Datapath: degree counts, visit marks, frontier and result registers.
//------------------------------------------------------------------------------
`default_nettype none
module gbt_dp #(
	parameter int MAX_VERTICES = 16,
	parameter int MAX_DEGREE   = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gbt_pkg::gbt_cmd_t cmd,
	output gbt_pkg::gbt_sts_t      sts,
	input  wire logic [1:0]        action,
	input  wire logic [4:0]        src_vertex,
	input  wire logic [4:0]        dst_vertex,
	input  wire logic [4:0]        vcount,
	output logic                   done,
	output logic [4:0]             visited_vertex,
	output logic                   last,
	output logic [1:0]             status
);
	import gbt_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int CW = $clog2(MAX_DEGREE + 1);
	localparam int FW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES * MAX_DEGREE);
	localparam int RW = VW + 1;

	logic [RW-1:0] n_eff;
	logic [1:0]    act_q;
	logic [RW-1:0] src_q, dst_q;
	logic          bad_q, full_q;
	logic [CW-1:0] deg_q [MAX_VERTICES];
	logic [1:0]    mark_q [MAX_VERTICES];
	logic [VW-1:0] cur_q;
	logic [CW-1:0] idx_q;
	logic [FW-1:0] head_q, tail_q;
	logic          lifo_q;
	logic [VW-1:0] adj_rd, fr_rd;
	logic [CW-1:0] cur_deg;
	logic [AW-1:0] adj_waddr, adj_raddr;
	logic [VW-1:0] fr_raddr;
	logic          push;

	// clamp register value and range-check input vertices
	always_comb begin
		if (vcount == 5'd0) begin
			n_eff = RW'(1);
		end else if (32'(vcount) > MAX_VERTICES) begin
			n_eff = RW'(MAX_VERTICES);
		end else begin
			n_eff = RW'(vcount);
		end
	end

	logic src_ok, dst_ok;
	assign src_ok = (src_vertex != 5'd0) && ({1'b0, src_vertex} <= 6'(n_eff));
	assign dst_ok = (dst_vertex != 5'd0) && ({1'b0, dst_vertex} <= 6'(n_eff));

	assign cur_deg   = deg_q[cur_q];
	assign adj_waddr = AW'(src_q[VW-1:0]) * AW'(MAX_DEGREE) + AW'(deg_q[src_q[VW-1:0]]);
	assign adj_raddr = AW'(cur_q) * AW'(MAX_DEGREE) + AW'(idx_q[DW-1:0]);

	gbt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_adj (
		.clk   (clk),
		.we    (cmd.edge_wr && act_q == ACT_ADD && !bad_q && !full_q),
		.waddr (adj_waddr),
		.wdata (dst_q[VW-1:0]),
		.raddr (adj_raddr),
		.rdata (adj_rd)
	);

	// push when the neighbour is in range and unvisited and the frontier has room
	assign push = cmd.scan_step && (RW'(adj_rd) < n_eff) && (mark_q[adj_rd] == MARK_FREE)
		&& (32'(tail_q) < MAX_VERTICES);

	assign fr_raddr = lifo_q ? VW'(tail_q - FW'(1)) : VW'(head_q);

	gbt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_fr (
		.clk   (clk),
		.we    (push),
		.waddr (VW'(tail_q)),
		.wdata (adj_rd),
		.raddr (fr_raddr),
		.rdata (fr_rd)
	);

	assign sts.is_walk   = (act_q == ACT_BFS) || (act_q == ACT_DFS);
	assign sts.bad       = bad_q;
	assign sts.scan_done = (idx_q >= cur_deg);
	assign sts.empty     = (head_q >= tail_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			src_q  <= RW'(src_vertex - 5'd1);
			dst_q  <= RW'(dst_vertex - 5'd1);
			bad_q  <= (action == ACT_ADD) ? !(src_ok && dst_ok)
				: (action != ACT_CLEAR) && !src_ok;
			full_q <= 32'(deg_q[VW'(src_vertex - 5'd1)]) >= MAX_DEGREE;
			lifo_q <= (action == ACT_DFS);
		end
		if (cmd.walk_init) begin
			cur_q <= src_q[VW-1:0];
		end else if (cmd.take) begin
			cur_q <= fr_rd;
		end
		if (cmd.walk_init || cmd.take) begin
			idx_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				deg_q[i]  <= '0;
				mark_q[i] <= MARK_FREE;
			end
			head_q <= '0;
			tail_q <= '0;
			done   <= 1'b0;
			visited_vertex <= '0;
			last   <= 1'b0;
			status <= ST_OK;
		end else begin
			done <= cmd.emit_stat || cmd.emit_cur;
			if (cmd.emit_stat) begin
				visited_vertex <= '0;
				last           <= 1'b1;
				status         <= bad_q ? ST_RANGE
					: (act_q == ACT_ADD && full_q) ? ST_FULL : ST_OK;
				if (cmd.clear && act_q == ACT_CLEAR) begin
					for (int i = 0; i < MAX_VERTICES; i++) begin
						deg_q[i] <= '0;
					end
				end else if (act_q == ACT_ADD && !bad_q && !full_q) begin
					deg_q[src_q[VW-1:0]] <= deg_q[src_q[VW-1:0]] + CW'(1);
				end
			end
			if (cmd.walk_init) begin
				for (int i = 0; i < MAX_VERTICES; i++) begin
					mark_q[i] <= (VW'(i) == src_q[VW-1:0]) ? MARK_DONE : MARK_FREE;
				end
				head_q <= '0;
				tail_q <= '0;
			end
			if (push) begin
				mark_q[adj_rd] <= MARK_WAIT;
				tail_q <= tail_q + FW'(1);
			end
			if (cmd.emit_cur) begin
				visited_vertex <= 5'(cur_q) + 5'd1;
				last           <= (head_q >= tail_q);
				status         <= ST_OK;
			end
			if (cmd.pop && head_q < tail_q) begin
				if (lifo_q) begin
					tail_q <= tail_q - FW'(1);
				end else begin
					head_q <= head_q + FW'(1);
				end
			end
			if (cmd.take) begin
				mark_q[fr_rd] <= MARK_DONE;
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/graph_bfs_dfs_traversal_top.sv
// Edge add and clear: status strobe registered from the EMIT state; busy one cycle.
// Run: each vertex is strobed once its adjacency RAM reads (RDREQ, SCAN per edge) are done;
// each further vertex follows one frontier pop (POP).
// One item at a time; busy falls in the cycle of the last result strobe.
// arst_n clears degree counts, visit marks, frontier pointers and vertex_count=16.
// Adjacency and frontier RAMs are not cleared; only written entries are read.
`default_nettype none
module graph_bfs_dfs_traversal_top #(
	parameter int MAX_VERTICES = 16,
	parameter int MAX_DEGREE   = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] action,
	input  wire logic [4:0] src_vertex,
	input  wire logic [4:0] dst_vertex,
	output logic            done,
	output logic [4:0]      visited_vertex,
	output logic            last,
	output logic [1:0]      status,
	input  wire logic       psel,
	input  wire logic       penable,
	input  wire logic       pwrite,
	input  wire logic [0:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import gbt_pkg::*;

	gbt_cmd_t   cmd;
	gbt_sts_t   sts;
	logic [4:0] vcount_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_VERTEX_COUNT) ? {27'd0, vcount_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 5'd16;
		end else if (psel && penable && pwrite && paddr == REG_VERTEX_COUNT) begin
			vcount_q <= pwdata[4:0];
		end
	end

	gbt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	gbt_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (action),
		.src_vertex     (src_vertex),
		.dst_vertex     (dst_vertex),
		.vcount         (vcount_q),
		.done           (done),
		.visited_vertex (visited_vertex),
		.last           (last),
		.status         (status)
	);
endmodule
`default_nettype wire

// File: hw/rtl/gbt_check.sv
//------------------------------------------------------------------------------
// gbt_check
// Port-level checks for the graph walker, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
module gbt_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [4:0] visited_vertex,
	input wire logic       last,
	input wire logic [1:0] status
);
	import gbt_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");
	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy) else $error("non-final result while idle");
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> visited_vertex == 5'd0 && last)
		else $error("error status result malformed");
	a_vertex_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && visited_vertex != 5'd0 |-> status == ST_OK)
		else $error("vertex result carries error status");
endmodule

bind graph_bfs_dfs_traversal_top gbt_check u_gbt_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.visited_vertex (visited_vertex),
	.last           (last),
	.status         (status)
);
`default_nettype wire
